[hw/rtl/mttf_pkg.sv]
// ----------------------------------------------------------------------------
// mttf_pkg
// Shared types and constants of the multi-term text filter.
// ----------------------------------------------------------------------------
package mttf_pkg;

	localparam int TERMS_DEF   = 8;
	localparam int PAT_LEN_DEF = 32;
	localparam int MAX_TERMS   = 8;

	localparam logic [1:0] MODE_LOAD = 2'd0;
	localparam logic [1:0] MODE_ATTR = 2'd1;
	localparam logic [1:0] MODE_TEXT = 2'd2;

	localparam logic [2:0] KIND_FUZZY     = 3'd0;
	localparam logic [2:0] KIND_SUBSTRING = 3'd1;
	localparam logic [2:0] KIND_PREFIX    = 3'd2;
	localparam logic [2:0] KIND_SUFFIX    = 3'd3;
	localparam logic [2:0] KIND_EQUAL     = 3'd4;

	typedef struct packed {
		logic       load;
		logic       clear;
		logic       take;
		logic [7:0] text_byte;
	} cell_ctl_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       exact;
		logic       inverted;
		logic [5:0] length;
		logic [2:0] set_id;
		logic       enabled;
	} term_attr_t;

	function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic exact);
		if (!exact && c >= 8'h41 && c <= 8'h5A)
			return c + 8'h20;
		return c;
	endfunction

endpackage

[hw/rtl/mttf_cell.sv]
// ----------------------------------------------------------------------------
// mttf_cell
// One window cell: holds one text byte and shifts it to the next cell.
// ----------------------------------------------------------------------------
module mttf_cell
	import mttf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctl_t  ctl,
	input  logic [7:0] shift_in,
	output logic [7:0] shift_out
);

	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (ctl.clear) begin
			byte_q <= '0;
		end else if (ctl.take) begin
			byte_q <= shift_in;
		end
	end

	assign shift_out = byte_q;

endmodule

[hw/rtl/mttf_term.sv]
// ----------------------------------------------------------------------------
// mttf_term
// One term: pattern bytes, attributes and running match state.
// ----------------------------------------------------------------------------
module mttf_term
	import mttf_pkg::*;
#(
	parameter int PAT_LEN = PAT_LEN_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cell_ctl_t                ctl,
	input  logic                     pat_we,
	input  logic [4:0]               pat_pos,
	input  logic                     attr_we,
	input  term_attr_t               attr_in,
	input  logic [PAT_LEN-1:0][7:0]  window,
	input  logic [5:0]               text_count,
	output term_attr_t               attr,
	output logic                     hit_now
);

	logic [PAT_LEN-1:0][7:0] pat_q;
	logic [5:0]              prog_q;
	logic                    seen_q;
	logic                    pre_q;

	logic [7:0]              c;
	logic [PAT_LEN-1:0][7:0] nwin;
	logic [5:0]              ncount;
	logic                    tail_cur;
	logic                    tail_new;
	logic [5:0]              prog_n;
	logic                    seen_n;
	logic                    pre_n;
	logic [5:0]              cnt_n;
	logic                    tail_n;
	logic                    m;

	always_ff @(posedge clk) begin
		if (pat_we)
			pat_q[pat_pos] <= ctl.text_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr <= '0;
		end else if (attr_we) begin
			attr <= attr_in;
		end
	end

	assign c = fold_byte(ctl.text_byte, attr.exact);

	always_comb begin
		nwin = window;
		for (int i = 0; i < PAT_LEN - 1; i++)
			nwin[i] = window[i+1];
		nwin[PAT_LEN-1] = ctl.text_byte;
		ncount = (text_count < 6'(PAT_LEN + 1)) ? text_count + 6'd1 : text_count;
		tail_cur = 1'b1;
		tail_new = 1'b1;
		for (int j = 0; j < PAT_LEN; j++) begin
			if (j >= PAT_LEN - int'(attr.length)) begin
				if (fold_byte(window[j], attr.exact) !=
				    pat_q[j - (PAT_LEN - int'(attr.length))])
					tail_cur = 1'b0;
				if (fold_byte(nwin[j], attr.exact) !=
				    pat_q[j - (PAT_LEN - int'(attr.length))])
					tail_new = 1'b0;
			end
		end
	end

	always_comb begin
		prog_n = prog_q;
		seen_n = seen_q;
		pre_n  = pre_q;
		cnt_n  = text_count;
		tail_n = tail_cur;
		if (ctl.take) begin
			cnt_n  = ncount;
			tail_n = tail_new;
			if (text_count < attr.length && c != pat_q[text_count[4:0]])
				pre_n = 1'b0;
			if (prog_q < attr.length && c == pat_q[prog_q[4:0]])
				prog_n = prog_q + 6'd1;
			if (attr.length != 0 && ncount >= attr.length && tail_new)
				seen_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_q <= '0;
			seen_q <= 1'b0;
			pre_q  <= 1'b1;
		end else if (ctl.clear) begin
			prog_q <= '0;
			seen_q <= 1'b0;
			pre_q  <= 1'b1;
		end else begin
			prog_q <= prog_n;
			seen_q <= seen_n;
			pre_q  <= pre_n;
		end
	end

	always_comb begin
		case (attr.kind)
			KIND_FUZZY:     m = (prog_n == attr.length);
			KIND_SUBSTRING: m = (attr.length == 0) || seen_n;
			KIND_PREFIX:    m = (attr.length == 0) || (cnt_n >= attr.length && pre_n);
			KIND_SUFFIX:    m = (attr.length == 0) || (cnt_n >= attr.length && tail_n);
			KIND_EQUAL:     m = (cnt_n == attr.length) && tail_n;
			default:        m = 1'b0;
		endcase
		hit_now = attr.enabled && (m ^ attr.inverted);
	end

endmodule

[hw/rtl/multi_term_text_filter_match.sv]
// ----------------------------------------------------------------------------
// multi_term_text_filter_match
// Multi-term text filter with a shifting byte window of cells.
// ----------------------------------------------------------------------------
// A beat is accepted whenever in_stall is low, and beats may follow back to
// back. A text byte shifts through a row of PAT_LEN window cells while each
// term updates its match state in the same cycle. A text beat with last set is
// evaluated in the cycle it is accepted, from the state its own byte produces;
// its result is registered in the output register, or in the skid slot while
// the output holds a stalled result. The output register and one skid slot
// let input continue while a result waits, and input stalls only while both hold a result.
module multi_term_text_filter_match
	import mttf_pkg::*;
#(
	parameter int TERMS   = TERMS_DEF,
	parameter int PAT_LEN = PAT_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] mode,
	input  logic [2:0] term_index,
	input  logic [4:0] char_pos,
	input  logic [7:0] byte_value,
	input  logic [2:0] match_kind,
	input  logic       case_exact,
	input  logic       negate,
	input  logic [5:0] pattern_length,
	input  logic [2:0] set_index,
	input  logic       term_enable,
	input  logic       byte_present,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       matched,
	output logic [7:0] term_hits
);

	logic                    acc;
	logic                    t_ok;
	cell_ctl_t               ctl;
	logic [PAT_LEN-1:0][7:0] window;
	logic [PAT_LEN:0][7:0]   chain;
	logic [5:0]              count_q;
	logic                    ev;
	logic [MAX_TERMS-1:0]    hit_now;
	term_attr_t              attr   [TERMS];
	term_attr_t              attr_in;
	logic [7:0]              set_has, set_hit;
	logic                    res_m;
	logic [7:0]              res_h;
	logic                    skid_q;
	logic                    skid_m_q;
	logic [7:0]              skid_h_q;

	assign in_stall = skid_q;
	assign acc      = in_valid && !in_stall;
	assign t_ok     = {29'd0, term_index} < 32'(TERMS);
	assign ev       = acc && mode == MODE_TEXT && last;

	always_comb begin
		ctl.text_byte = byte_value;
		ctl.load  = acc && ((mode == MODE_LOAD && t_ok && {27'd0, char_pos} < 32'(PAT_LEN)) ||
		                    (mode == MODE_ATTR && t_ok));
		ctl.take  = acc && mode == MODE_TEXT && byte_present;
		ctl.clear = ctl.load || ev;
	end

	assign chain[PAT_LEN] = byte_value;
	for (genvar i = 0; i < PAT_LEN; i++) begin : g_win
		mttf_cell u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl),
			.shift_in(chain[i+1]), .shift_out(chain[i])
		);
		assign window[i] = chain[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			if (ctl.clear)
				count_q <= '0;
			else if (ctl.take && count_q < 6'(PAT_LEN + 1))
				count_q <= count_q + 6'd1;
		end
	end

	always_comb begin
		attr_in.kind     = match_kind;
		attr_in.exact    = case_exact;
		attr_in.inverted = negate;
		attr_in.length   = (pattern_length > 6'(PAT_LEN)) ? 6'(PAT_LEN) : pattern_length;
		attr_in.set_id   = set_index;
		attr_in.enabled  = term_enable;
	end

	for (genvar t = 0; t < MAX_TERMS; t++) begin : g_term
		if (t < TERMS) begin : g_on
			mttf_term #(.PAT_LEN(PAT_LEN)) u_term (
				.clk(clk), .arst_n(arst_n), .ctl(ctl),
				.pat_we(ctl.load && mode == MODE_LOAD && term_index == 3'(t)),
				.pat_pos(char_pos),
				.attr_we(ctl.load && mode == MODE_ATTR && term_index == 3'(t)),
				.attr_in(attr_in), .window(window), .text_count(count_q),
				.attr(attr[t]), .hit_now(hit_now[t])
			);
		end else begin : g_off
			assign hit_now[t] = 1'b0;
		end
	end

	always_comb begin
		set_has = '0;
		set_hit = '0;
		for (int t = 0; t < TERMS; t++) begin
			if (attr[t].enabled) begin
				set_has[attr[t].set_id] = 1'b1;
				if (hit_now[t])
					set_hit[attr[t].set_id] = 1'b1;
			end
		end
		res_m = (set_has & ~set_hit) == 8'd0;
		res_h = hit_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			skid_q    <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= skid_q || ev;
				skid_q    <= skid_q && ev;
			end else if (ev) begin
				if (!out_valid)
					out_valid <= 1'b1;
				else
					skid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (skid_q) begin
				matched   <= skid_m_q;
				term_hits <= skid_h_q;
			end else begin
				matched   <= res_m;
				term_hits <= res_h;
			end
			skid_m_q <= res_m;
			skid_h_q <= res_h;
		end else if (ev) begin
			if (!out_valid) begin
				matched   <= res_m;
				term_hits <= res_h;
			end else begin
				skid_m_q <= res_m;
				skid_h_q <= res_h;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) ev |-> count_q <= 6'(PAT_LEN + 1))
		else $error("text count beyond saturation");
	assert property (@(posedge clk) disable iff (!arst_n) skid_q |-> out_valid)
		else $error("skid slot full while output empty");
	assert property (@(posedge clk) disable iff (!arst_n) $past(ctl.clear) |-> count_q == 6'd0)
		else $error("text count not cleared");

endmodule

[dv/tb_multi_term_text_filter_match.sv]
// ----------------------------------------------------------------------------
// tb_multi_term_text_filter_match
// Self-checking bench for the multi-term text filter. Loads pattern bytes
// and term attributes, streams text strings, and compares every result beat
// against a local predictor of the term-set match logic.
// ----------------------------------------------------------------------------
module tb_multi_term_text_filter_match;
	import mttf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NT = 8;
	localparam int PL = 32;
	localparam int WATCH_LIMIT = 5000;
	localparam int MODE_SPARE = 3;
	localparam int KIND_UNKNOWN = 5;

	typedef struct {
		logic [1:0] mode;
		logic [2:0] term_index;
		logic [4:0] char_pos;
		logic [7:0] byte_value;
		logic [2:0] match_kind;
		logic       case_exact;
		logic       negate;
		logic [5:0] pattern_length;
		logic [2:0] set_index;
		logic       term_enable;
		logic       byte_present;
		logic       last;
	} beat_t;

	typedef struct {
		logic       matched;
		logic [7:0] term_hits;
	} verdict_t;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 0;
	logic [1:0] mode = 0;
	logic [2:0] term_index = 0, match_kind = 0, set_index = 0;
	logic [4:0] char_pos = 0;
	logic [7:0] byte_value = 0;
	logic case_exact = 0, negate = 0, term_enable = 0, byte_present = 0, last = 0;
	logic [5:0] pattern_length = 0;
	logic matched;
	logic [7:0] term_hits;

	multi_term_text_filter_match dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// predictor state
	logic [7:0] pat_mem [NT*PL];
	logic [2:0] t_kind [NT];
	logic       t_exact [NT], t_inv [NT], t_en [NT], sub_seen [NT], pre_ok [NT];
	int         t_len [NT], t_set [NT], fz_prog [NT];
	logic [7:0] window [PL];
	int         txt_cnt;

	verdict_t verdicts_due [$];
	int tx_idle_pct = 0, rx_idle_pct = 0, hold_cycles = 0;
	int mismatches = 0, idle_cycles = 0;

	function automatic logic [7:0] fold_c(logic [7:0] c, int t);
		if (!t_exact[t] && c >= 8'h41 && c <= 8'h5A) return c + 8'h20;
		return c;
	endfunction

	function automatic void clear_text();
		for (int t = 0; t < NT; t++) begin
			fz_prog[t] = 0; sub_seen[t] = 0; pre_ok[t] = 1;
		end
		for (int j = 0; j < PL; j++) window[j] = 0;
		txt_cnt = 0;
	endfunction

	function automatic bit tail_eq(int t, int l);
		for (int j = 0; j < l; j++)
			if (fold_c(window[PL-l+j], t) != pat_mem[t*PL+j]) return 0;
		return 1;
	endfunction

	function automatic void take_byte(logic [7:0] b);
		logic [7:0] c;
		for (int t = 0; t < NT; t++) begin
			c = fold_c(b, t);
			if (txt_cnt < t_len[t] && c != pat_mem[t*PL+txt_cnt]) pre_ok[t] = 0;
			if (fz_prog[t] < t_len[t] && c == pat_mem[t*PL+fz_prog[t]]) fz_prog[t]++;
		end
		for (int j = 0; j < PL-1; j++) window[j] = window[j+1];
		window[PL-1] = b;
		if (txt_cnt < PL+1) txt_cnt++;
		for (int t = 0; t < NT; t++)
			if (t_len[t] > 0 && txt_cnt >= t_len[t] && tail_eq(t, t_len[t])) sub_seen[t] = 1;
	endfunction

	function automatic bit term_says(int t);
		bit m;
		int l;
		l = t_len[t];
		case (t_kind[t])
			KIND_FUZZY:     m = (fz_prog[t] == l);
			KIND_SUBSTRING: m = (l == 0) || sub_seen[t];
			KIND_PREFIX:    m = (l == 0) || (txt_cnt >= l && pre_ok[t]);
			KIND_SUFFIX:    m = (l == 0) || (txt_cnt >= l && tail_eq(t, l));
			KIND_EQUAL:     m = (txt_cnt == l) && tail_eq(t, l);
			default:        m = 0;
		endcase
		return t_inv[t] ? !m : m;
	endfunction

	function automatic void predict(beat_t bt);
		verdict_t v;
		logic [7:0] has, hit;
		if (bt.mode == MODE_LOAD) begin
			pat_mem[bt.term_index*PL+bt.char_pos] = bt.byte_value;
			clear_text();
		end else if (bt.mode == MODE_ATTR) begin
			t_kind[bt.term_index]  = bt.match_kind;
			t_exact[bt.term_index] = bt.case_exact;
			t_inv[bt.term_index]   = bt.negate;
			t_len[bt.term_index]   = bt.pattern_length > PL ? PL : bt.pattern_length;
			t_set[bt.term_index]   = bt.set_index;
			t_en[bt.term_index]    = bt.term_enable;
			clear_text();
		end else if (bt.mode == MODE_TEXT) begin
			if (bt.byte_present) take_byte(bt.byte_value);
			if (bt.last) begin
				has = 0; hit = 0; v.term_hits = 0;
				for (int t = 0; t < NT; t++)
					if (t_en[t]) begin
						has[t_set[t]] = 1;
						if (term_says(t)) begin
							v.term_hits[t] = 1; hit[t_set[t]] = 1;
						end
					end
				v.matched = ((has & ~hit) == 0);
				verdicts_due.push_back(v);
				clear_text();
			end
		end
	endfunction

	task automatic send_beat(beat_t bt);
		while ($urandom_range(99) < tx_idle_pct) begin
			@(negedge clk) in_valid <= 0;
		end
		@(negedge clk);
		mode <= bt.mode; term_index <= bt.term_index; char_pos <= bt.char_pos;
		byte_value <= bt.byte_value; match_kind <= bt.match_kind;
		case_exact <= bt.case_exact; negate <= bt.negate;
		pattern_length <= bt.pattern_length; set_index <= bt.set_index;
		term_enable <= bt.term_enable; byte_present <= bt.byte_present;
		last <= bt.last; in_valid <= 1;
		do @(posedge clk); while (in_stall);
		predict(bt);
	endtask

	task automatic release_bus();
		@(negedge clk) in_valid <= 0;
	endtask

	task automatic wait_drain();
		release_bus();
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic beat_t blank();
		beat_t bt;
		bt = '{default: 0};
		return bt;
	endfunction

	task automatic load_byte(int t, int p, logic [7:0] b);
		beat_t bt;
		bt = blank(); bt.mode = MODE_LOAD; bt.term_index = t; bt.char_pos = p;
		bt.byte_value = b; bt.last = $urandom_range(1);
		send_beat(bt);
	endtask

	task automatic set_term(int t, int k, bit ce, bit ng, int l, int s, bit en);
		beat_t bt;
		bt = blank(); bt.mode = MODE_ATTR; bt.term_index = t; bt.match_kind = k;
		bt.case_exact = ce; bt.negate = ng; bt.pattern_length = l;
		bt.set_index = s; bt.term_enable = en; bt.last = $urandom_range(1);
		bt.byte_value = $urandom;
		send_beat(bt);
	endtask

	task automatic text_beat(logic [7:0] b, bit present, bit fin);
		beat_t bt;
		bt = blank(); bt.mode = MODE_TEXT; bt.byte_value = b;
		bt.byte_present = present; bt.last = fin;
		send_beat(bt);
	endtask

	task automatic send_string(string s);
		for (int i = 0; i < s.len(); i++) text_beat(s[i], 1, i == s.len()-1);
		if (s.len() == 0) text_beat(8'h00, 0, 1);
	endtask

	function automatic logic [7:0] letter();
		return 8'h61 + $urandom_range(3);
	endfunction

	task automatic test_pattern_fill();
		for (int t = 0; t < NT; t++)
			for (int p = 0; p < PL; p++) load_byte(t, p, letter());
	endtask

	task automatic test_directed();
		beat_t bt;
		send_string("ab");
		load_byte(0, 0, "a"); load_byte(0, 1, "b");
		set_term(0, KIND_FUZZY, 0, 0, 2, 0, 1);
		send_string("xAyB");
		set_term(0, KIND_EQUAL, 1, 0, 0, 0, 1);
		send_string("");
		send_string("a");
		set_term(0, KIND_UNKNOWN, 0, 1, 3, 7, 1);
		set_term(1, KIND_SUFFIX, 0, 0, 63, 7, 1);
		send_string("abc");
		set_term(1, KIND_PREFIX, 1, 1, 0, 1, 1);
		text_beat("a", 1, 0);
		bt = blank(); bt.mode = MODE_SPARE; bt.last = 1; send_beat(bt);
		text_beat(8'hFF, 1, 0);
		text_beat(8'h00, 0, 0);
		load_byte(7, 31, 8'hFF);
		text_beat("b", 1, 0);
		text_beat(8'h00, 0, 1);
		set_term(0, 7, 1, 0, 32, 0, 0);
		set_term(1, KIND_SUBSTRING, 0, 0, 2, 0, 1);
		send_string("zzAB");
		wait_drain();
	endtask

	task automatic random_attr();
		int l;
		l = ($urandom_range(5) == 0) ? $urandom_range(63) : $urandom_range(6);
		set_term($urandom_range(NT-1), $urandom_range(7), $urandom_range(1),
			$urandom_range(1), l, $urandom_range(3) == 0 ? $urandom_range(7) :
			$urandom_range(1), $urandom_range(3) != 0);
	endtask

	task automatic random_string();
		int n, t;
		logic [7:0] b;
		n = $urandom_range(8) == 0 ? $urandom_range(40) : $urandom_range(8);
		t = $urandom_range(NT-1);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: b = $urandom;
				1, 2: b = letter() - 8'h20;
				3, 4, 5: b = pat_mem[t*PL + (i % PL)];
				default: b = letter();
			endcase
			text_beat(b, $urandom_range(15) != 0, i == n-1);
		end
		if (n == 0) text_beat($urandom, $urandom_range(1), 1);
	endtask

	task automatic test_random(int beats, int tx_pct, int rx_pct);
		tx_idle_pct = tx_pct; rx_idle_pct = rx_pct;
		for (int i = 0; i < NT; i++) random_attr();
		for (int i = 0; i < beats; ) begin
			case ($urandom_range(19))
				0: begin load_byte($urandom_range(NT-1), $urandom_range(PL-1),
					$urandom_range(1) ? letter() : 8'($urandom)); i++; end
				1, 2: begin random_attr(); i++; end
				3: begin
					text_beat($urandom, $urandom_range(1), 0); i++;
				end
				default: begin random_string(); i += 5; end
			endcase
		end
		wait_drain();
	endtask

	task automatic test_backpressure();
		tx_idle_pct = 0;
		hold_cycles = 300;
		for (int i = 0; i < 60; i++) text_beat(letter(), 1, $urandom_range(2) == 0);
		wait_drain();
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1;
			hold_cycles <= hold_cycles - 1;
		end else
			out_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	always @(posedge clk) begin
		verdict_t v;
		if (arst_n && out_valid && !out_stall) begin
			if (verdicts_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %b %h", matched, term_hits);
			end else begin
				v = verdicts_due.pop_front();
				if (matched !== v.matched || term_hits !== v.term_hits) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %b %h, got %b %h",
							v.matched, v.term_hits, matched, term_hits);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("tb_multi_term_text_filter_match: FAIL");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < NT*PL; i++) pat_mem[i] = 0;
		for (int t = 0; t < NT; t++) begin
			t_kind[t] = 0; t_exact[t] = 0; t_inv[t] = 0; t_en[t] = 0;
			t_len[t] = 0; t_set[t] = 0;
		end
		clear_text();
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1;
		test_pattern_fill();
		test_directed();
		test_random(260, 18, 67);
		test_random(260, 67, 18);
		test_random(260, 0, 0);
		test_backpressure();
		if (mismatches == 0 && verdicts_due.size() == 0)
			$display("tb_multi_term_text_filter_match: PASS");
		else
			$display("tb_multi_term_text_filter_match: FAIL");
		$finish;
	end
endmodule

[multi_term_text_filter_match.f]
hw/rtl/mttf_pkg.sv
hw/rtl/mttf_cell.sv
hw/rtl/mttf_term.sv
hw/rtl/multi_term_text_filter_match.sv
dv/tb_multi_term_text_filter_match.sv
